// ===== sv/ssir_pkg.sv =====
package ssir_pkg;

    // capacity, derived count width and fixed widths
    localparam int CAPACITY  = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;
    localparam int ST_W      = 3;

    // operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [ST_W-1:0] ST_REMOVED = 3'd2;
    localparam logic [ST_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic cmp;
        logic upd;
    } t_cmd;

endpackage

// ===== sv/ssir_ctrl.sv =====
module ssir_ctrl import ssir_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // output register can take a new result
    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        if (o_cmd.upd) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/ssir_dp.sv =====
module ssir_dp import ssir_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic                        i_op,
    input  logic signed [VAL_W-1:0]     i_value,
    output logic        [ST_W-1:0]      o_status,
    output logic        [OUT_CNT_W-1:0] o_element_count
);

    logic signed [VAL_W-1:0] r_cell [CAPACITY];
    logic signed [VAL_W-1:0] n_cell [CAPACITY];
    logic        [CAPACITY-1:0] r_lt;
    logic        [CAPACITY-1:0] r_eq;
    logic signed [VAL_W-1:0] r_key;
    logic                    r_op;
    logic        [CNT_W-1:0] r_count;
    logic        [CNT_W-1:0] n_count;
    logic        [ST_W-1:0]  r_status;
    logic        [ST_W-1:0]  n_status;
    logic                    found;
    logic                    full;
    logic                    do_ins;
    logic                    do_rem;

    // decision from the registered cell flags
    assign found  = |r_eq;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign do_ins = (r_op == OP_ADD) && !found && !full;
    assign do_rem = (r_op == OP_REMOVE) && found;

    always_comb begin
        n_count  = r_count;
        n_status = ST_ABSENT;
        priority if (r_op == OP_ADD && found) begin
            n_status = ST_PRESENT;
        end else if (r_op == OP_ADD && full) begin
            n_status = ST_FULL;
        end else if (r_op == OP_ADD) begin
            n_status = ST_ADDED;
            n_count  = r_count + CNT_W'(1);
        end else if (found) begin
            n_status = ST_REMOVED;
            n_count  = r_count - CNT_W'(1);
        end else begin
            n_status = ST_ABSENT;
        end
    end

    // latch the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_value;
            r_op  <= i_op;
        end
    end

    // count and result status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.upd) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_status <= n_status;
        end
    end

    // row of cells, each compares against the key and shifts locally
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic cell_valid;
        logic signed [VAL_W-1:0] below_val;
        logic signed [VAL_W-1:0] above_val;
        logic below_lt;

        assign cell_valid = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign below_val = r_key;
            assign below_lt  = 1'b0;
        end else begin : g_mid
            assign below_val = r_cell[g-1];
            assign below_lt  = r_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign above_val = r_cell[g];
        end else begin : g_inner
            assign above_val = r_cell[g+1];
        end

        // next cell value
        always_comb begin
            n_cell[g] = r_cell[g];
            if (i_cmd.upd && !r_lt[g]) begin
                if (do_ins) begin
                    n_cell[g] = below_lt || (g == 0) ? r_key : below_val;
                end else if (do_rem) begin
                    n_cell[g] = above_val;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[g] <= n_cell[g];
            if (i_cmd.cmp) begin
                r_lt[g] <= cell_valid && (r_cell[g] < r_key);
                r_eq[g] <= cell_valid && (r_cell[g] == r_key);
            end
        end
    end

    assign o_status        = r_status;
    assign o_element_count = OUT_CNT_W'(r_count);

endmodule

// ===== sv/sorted_set_insert_remove_unit.sv =====
// sorted set of distinct signed 32-bit values, held in ascending order
//
// input channel: i_in_valid / o_in_stall carry i_op (0 add, 1 remove) and
// i_value. output channel: o_out_valid / i_out_stall carry o_status
// (added, present, removed, absent, full) and o_element_count.
// a transfer happens at a rising edge with valid high and stall low.
//
// each item goes through load, compare and update: the transfer latches it,
// the compare step registers the per-cell compare flags, and the update step
// shifts the cell row, updates the count and loads the result register once
// the result register is free. a new item is accepted only after that update;
// o_in_stall is high while an item is in work.
//
// a stalled result holds in the output register; the next item is still
// accepted and compared, and its update waits until the result register
// frees up. reset clears the count to zero and drops o_out_valid; cell
// contents are left as they are and count as empty.
module sorted_set_insert_remove_unit import ssir_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic signed [VAL_W-1:0]     i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic        [ST_W-1:0]      o_status,
    output logic        [OUT_CNT_W-1:0] o_element_count
);

    t_cmd s_cmd;

    ssir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (s_cmd)
    );

    ssir_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .i_op            (i_op),
        .i_value         (i_value),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_element_count <= OUT_CNT_W'(CAPACITY)))
        else $error("element count above capacity");

    // full is reported only at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |->
            (o_element_count == OUT_CNT_W'(CAPACITY)))
        else $error("full status below capacity");

    // an add leaves at least one element
    a_added_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_ADDED) |-> (o_element_count != '0))
        else $error("added status with empty set");

    // an accepted item is compared in the next cycle
    a_transfer_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> s_cmd.cmp)
        else $error("accepted item not compared");

endmodule
